/* design/tcw_pkg.sv */
package tcw_pkg;

  // action codes on the input channel
  localparam logic [1:0] ACT_PRINT = 2'd0;
  localparam logic [1:0] ACT_ATTR  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // command kinds after classification
  localparam logic [2:0] K_CHAR  = 3'd0;
  localparam logic [2:0] K_LF    = 3'd1;
  localparam logic [2:0] K_CR    = 3'd2;
  localparam logic [2:0] K_ATTR  = 3'd3;
  localparam logic [2:0] K_CLEAR = 3'd4;
  localparam logic [2:0] K_READ  = 3'd5;

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] ATTR_RESET = 8'h0F;
  localparam logic [7:0] CH_BLANK   = 8'h00;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [10:0] index;
  } cmd_t;

  // front to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  // back to front
  typedef struct packed {
    logic pop;
    logic busy;
  } back_ctl_t;

endpackage

/* design/tcw_ram.sv */
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/tcw_front.sv */
module tcw_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          action,
  input  logic [7:0]          data_byte,
  input  logic [10:0]         cell_index,
  input  tcw_pkg::back_ctl_t  ctl,
  output tcw_pkg::cmd_req_t   req
);

  tcw_pkg::cmd_t q [2];
  tcw_pkg::cmd_t cmd_in;
  logic [1:0]    count;
  logic          wr_ptr;
  logic          rd_ptr;
  logic          push_ok;
  logic          pop_ok;

  always_comb begin
    cmd_in.data  = data_byte;
    cmd_in.index = cell_index;
    case (action)
      tcw_pkg::ACT_PRINT: begin
        if (data_byte == tcw_pkg::CH_LF) begin
          cmd_in.kind = tcw_pkg::K_LF;
        end else if (data_byte == tcw_pkg::CH_CR) begin
          cmd_in.kind = tcw_pkg::K_CR;
        end else begin
          cmd_in.kind = tcw_pkg::K_CHAR;
        end
      end
      tcw_pkg::ACT_ATTR:  cmd_in.kind = tcw_pkg::K_ATTR;
      tcw_pkg::ACT_CLEAR: cmd_in.kind = tcw_pkg::K_CLEAR;
      default:            cmd_in.kind = tcw_pkg::K_READ;
    endcase
  end

  // closed while both queue entries are held or the screen is being blanked after reset
  assign full    = (count == 2'd2) || ctl.busy;
  assign push_ok = push && !full;
  assign pop_ok  = ctl.pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 2'd1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  assign req.valid = (count != 2'd0);
  assign req.cmd   = q[rd_ptr];

endmodule

/* design/tcw_back.sv */
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int LINES   = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  tcw_pkg::cmd_req_t  req,
  output tcw_pkg::back_ctl_t ctl,
  output logic               empty,
  input  logic               pop,
  output logic [4:0]         cursor_line,
  output logic [6:0]         cursor_column,
  output logic [7:0]         read_char,
  output logic [7:0]         read_attr,
  output logic               scrolled
);

  localparam int CELLS = COLUMNS * LINES;
  localparam int AW    = $clog2(CELLS);
  localparam int LW    = $clog2(LINES + 1);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int COPY  = CELLS - COLUMNS;

  localparam logic [LW-1:0] LINES_V = LW'(LINES);
  localparam logic [CW-1:0] COLS_V  = CW'(COLUMNS);
  localparam logic [AW-1:0] COLS_A  = AW'(COLUMNS);
  localparam logic [AW-1:0] COPY_A  = AW'(COPY);
  localparam logic [AW-1:0] LAST_A  = AW'(CELLS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;

  localparam logic [1:0] FK_INIT   = 2'd0;
  localparam logic [1:0] FK_CLEAR  = 2'd1;
  localparam logic [1:0] FK_SCROLL = 2'd2;

  logic [2:0]    state;
  logic [1:0]    fill_kind;
  logic [AW-1:0] ptr;
  logic [AW-1:0] waddr_d;
  logic          pend;
  tcw_pkg::cmd_t cmd;
  logic [7:0]    attr;
  logic [LW-1:0] line;
  logic [CW-1:0] col;
  logic          sc;
  logic          out_valid;
  logic [7:0]    rc;
  logic [7:0]    ra;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic [AW-1:0] pos;
  logic          idx_ok;
  logic          char_wr;

  assign pos     = AW'(int'(line) * COLUMNS + int'(col));
  assign idx_ok  = 32'(cmd.index) < 32'(CELLS);
  assign char_wr = (state == S_EXEC) && (cmd.kind == tcw_pkg::K_CHAR) &&
                   (line < LINES_V) && (col < COLS_V);

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // cells are stored as {char, attr}
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = {tcw_pkg::CH_BLANK, attr};
    ram_raddr = AW'(ptr + COLS_A);
    case (state)
      S_EXEC: begin
        ram_raddr = AW'(cmd.index);
        ram_waddr = pos;
        ram_wdata = {cmd.data, attr};
        ram_we    = char_wr;
      end
      S_COPY: begin
        ram_we    = pend;
        ram_waddr = waddr_d;
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ctl.pop  = (state == S_IDLE) && req.valid && !out_valid;
  assign ctl.busy = (state == S_FILL) && (fill_kind == FK_INIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fill_kind <= FK_INIT;
      ptr       <= '0;
      pend      <= 1'b0;
      attr      <= tcw_pkg::ATTR_RESET;
      line      <= '0;
      col       <= '0;
      sc        <= 1'b0;
      out_valid <= 1'b0;
      rc        <= 8'h00;
      ra        <= 8'h00;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ctl.pop) begin
            cmd   <= req.cmd;
            sc    <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd.kind)
            tcw_pkg::K_ATTR: begin
              attr      <= cmd.data;
              rc        <= 8'h00;
              ra        <= 8'h00;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
            tcw_pkg::K_CLEAR: begin
              ptr       <= '0;
              fill_kind <= FK_CLEAR;
              state     <= S_FILL;
            end
            tcw_pkg::K_READ: begin
              if (idx_ok) begin
                state <= S_RDWAIT;
              end else begin
                rc        <= 8'h00;
                ra        <= 8'h00;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end
            end
            default: begin
              if (line >= LINES_V) begin
                // pending scroll comes first, then this state runs again
                ptr   <= '0;
                pend  <= 1'b0;
                sc    <= 1'b1;
                state <= S_COPY;
              end else if (cmd.kind == tcw_pkg::K_LF) begin
                line      <= line + LW'(1);
                col       <= '0;
                rc        <= 8'h00;
                ra        <= 8'h00;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end else if (cmd.kind == tcw_pkg::K_CR) begin
                col       <= '0;
                rc        <= 8'h00;
                ra        <= 8'h00;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end else if (col >= COLS_V) begin
                // wrap, may leave a scroll pending for the next cycle
                col  <= '0;
                line <= line + LW'(1);
              end else begin
                col       <= col + CW'(1);
                rc        <= 8'h00;
                ra        <= 8'h00;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end
            end
          endcase
        end
        S_RDWAIT: begin
          rc        <= ram_rdata[15:8];
          ra        <= ram_rdata[7:0];
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_COPY: begin
          // read one line below, write it back in the following cycle
          if (ptr < COPY_A) begin
            pend    <= 1'b1;
            waddr_d <= ptr;
            ptr     <= ptr + AW'(1);
          end else begin
            pend      <= 1'b0;
            fill_kind <= FK_SCROLL;
            state     <= S_FILL;
          end
        end
        S_FILL: begin
          if (ptr == LAST_A) begin
            case (fill_kind)
              FK_CLEAR: begin
                line      <= '0;
                col       <= '0;
                rc        <= 8'h00;
                ra        <= 8'h00;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end
              FK_SCROLL: begin
                if (line != '0) begin
                  line <= line - LW'(1);
                end
                col   <= '0;
                state <= S_EXEC;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty         = !out_valid;
  assign cursor_line   = 5'(line);
  assign cursor_column = 7'(col);
  assign read_char     = rc;
  assign read_attr     = ra;
  assign scrolled      = sc;

  // a waiting result freezes the engine, so the cursor ports stay put
  a_result_holds_engine: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_IDLE)
    else $error("engine moved while a result was waiting");

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> line <= LINES_V)
    else $error("cursor line past pending scroll position");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    col <= COLS_V)
    else $error("cursor column out of range");

  a_scroll_col: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && sc |-> col <= CW'(1))
    else $error("scroll left the cursor away from the line start");

  a_read_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rc != 8'h00 || ra != 8'h00) |-> cmd.kind == tcw_pkg::K_READ)
    else $error("cell data reported for a non-read request");

endmodule

/* design/text_console_writer.sv */
// text-mode console engine: a screen of LINES x COLUMNS cells, each a
// character and an attribute byte, with a cursor and a current attribute.
// requests enter through a queue port: an item is taken when push is high
// and full is low. action selects print, set attribute, clear or read cell.
// every request gives exactly one result, shown while empty is low and
// taken when pop is high; cursor_line/cursor_column give the cursor after
// the request, read_char/read_attr the addressed cell for a read.
// a two-entry request queue sits in front of the engine, so push keeps
// being taken while a result waits; the engine only starts the next request
// once the previous result has been popped, and holds while pop stays low.
// print, newline, carriage return and set attribute pass the idle and the
// execute state; a read adds a wait state for the memory, and a print that
// wraps the line runs the execute state again. a scroll walks the screen
// memory one cell a cycle, copying each line up and blanking the last one.
// clear blanks every cell in the current attribute and homes the cursor.
// reset (rst, synchronous) starts a clearing pass over every cell that
// blanks the screen in attribute 0x0F; full stays high until it ends.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int LINES   = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [10:0] cell_index,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  cursor_line,
  output logic [6:0]  cursor_column,
  output logic [7:0]  read_char,
  output logic [7:0]  read_attr,
  output logic        scrolled
);

  tcw_pkg::cmd_req_t  req;
  tcw_pkg::back_ctl_t ctl;

  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .data_byte  (data_byte),
    .cell_index (cell_index),
    .ctl        (ctl),
    .req        (req)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .ctl           (ctl),
    .empty         (empty),
    .pop           (pop),
    .cursor_line   (cursor_line),
    .cursor_column (cursor_column),
    .read_char     (read_char),
    .read_attr     (read_attr),
    .scrolled      (scrolled)
  );

endmodule
